// ===== rtl/bsk_pkg.sv =====
// ----------------------------------------------------------------------------
// Biot-Savart kernel package
// Widths, latencies, status codes and payload types that are shared by the
// kernel pipeline and its square-root and divider units.
// ----------------------------------------------------------------------------
package bsk_pkg;

  // Number format of coordinates and results.
  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int SQRT_GUARD  = 32;

  // Exact intermediate widths.
  localparam int DIFF_W    = COORD_WIDTH + 1;
  localparam int PROD_W    = DIFF_W + COORD_WIDTH;
  localparam int SQ_W      = 2 * DIFF_W;
  localparam int CROSS_W   = PROD_W + 1;
  localparam int MAG_W     = 2 * COORD_WIDTH + 1;
  localparam int SUM_W     = 2 * COORD_WIDTH + 2;
  localparam int ROOT_W    = COORD_WIDTH + 1 + SQRT_GUARD;
  localparam int DEN_W     = SUM_W + ROOT_W;
  localparam int NUM_SHIFT = 2 * FRAC_BITS + SQRT_GUARD;
  localparam int NUM_W     = MAG_W + NUM_SHIFT;
  localparam int QUO_W     = COORD_WIDTH + 1;
  localparam int HI_W      = NUM_W - QUO_W;
  localparam int REM_W     = ((HI_W > DEN_W) ? HI_W : DEN_W) + 1;

  // Limb split of the denominator multiplier.
  localparam int LIMB_W  = 32;
  localparam int NA      = (SUM_W + LIMB_W - 1) / LIMB_W;
  localparam int NB      = (ROOT_W + LIMB_W - 1) / LIMB_W;
  localparam int MPROD_W = (NA + NB) * LIMB_W;

  // Pipeline latencies in cycles.
  localparam int SQRT_LAT = ROOT_W;
  localparam int MUL_LAT  = 3;
  localparam int DIV_LAT  = QUO_W + 2;
  localparam int MAG_LAT  = SQRT_LAT + MUL_LAT;
  localparam int FLAG_LAT = MAG_LAT + DIV_LAT;
  localparam int PIPE_LAT = 4 + FLAG_LAT + 1;

  // Result status codes.
  typedef logic [1:0] status_t;
  localparam status_t STATUS_OK         = 2'd0;
  localparam status_t STATUS_COINCIDENT = 2'd1;
  localparam status_t STATUS_SAT        = 2'd2;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] eval_x;
    logic signed [COORD_WIDTH-1:0] eval_y;
    logic signed [COORD_WIDTH-1:0] eval_z;
    logic signed [COORD_WIDTH-1:0] src_x;
    logic signed [COORD_WIDTH-1:0] src_y;
    logic signed [COORD_WIDTH-1:0] src_z;
    logic signed [COORD_WIDTH-1:0] elem_x;
    logic signed [COORD_WIDTH-1:0] elem_y;
    logic signed [COORD_WIDTH-1:0] elem_z;
  } item_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] field_x;
    logic signed [COORD_WIDTH-1:0] field_y;
    logic signed [COORD_WIDTH-1:0] field_z;
    status_t                       status;
  } result_t;

endpackage

// ===== rtl/biot_savart_point_kernel.sv =====
// ----------------------------------------------------------------------------
// Biot-Savart point kernel
// Streams -(d x e) / |d|^3 for d = eval - src, in saturated Q15.16.
// ----------------------------------------------------------------------------
// Usage:
//   The item channel (item_valid, item_ready, item) takes one evaluation
//   point, source point and current element per transaction. The result
//   channel (result_valid, result_ready, result) returns the three field
//   components and a status code: ok, coincident points (zero field) or
//   saturated.
//   Throughput is one transaction per cycle while results are taken. The
//   pipeline has four front stages for difference, products and
//   magnitudes, one stage per root bit in the square-root unit, three
//   stages for the limb multiplier forming |d|^3, one stage per quotient
//   bit plus entry and rounding stages in the divider, and an output stage.
//   The whole pipeline advances together; when the receiver stalls with a
//   result pending, every stage holds and item_ready drops, so nothing is
//   lost or repeated. Bubbles move with the data.
//   Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module biot_savart_point_kernel import bsk_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  typedef struct packed {
    logic [2:0] rneg;
    logic       coinc;
  } flag_t;

  logic                adv;
  logic [PIPE_LAT-1:0] vld;

  // The pipeline moves when the output register is free or being taken.
  assign adv          = !vld[PIPE_LAT-1] || result_ready;
  assign item_ready   = adv;
  assign result_valid = vld[PIPE_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[PIPE_LAT-2:0], item_valid};
    end
  end

  // Stage 1: coordinate differences.
  logic signed [COORD_WIDTH-1:0] ev [3];
  logic signed [COORD_WIDTH-1:0] sv [3];
  logic signed [COORD_WIDTH-1:0] el [3];
  logic signed [DIFF_W-1:0]      d1 [3];
  logic signed [COORD_WIDTH-1:0] e1 [3];

  assign ev[0] = item.eval_x;
  assign ev[1] = item.eval_y;
  assign ev[2] = item.eval_z;
  assign sv[0] = item.src_x;
  assign sv[1] = item.src_y;
  assign sv[2] = item.src_z;
  assign el[0] = item.elem_x;
  assign el[1] = item.elem_y;
  assign el[2] = item.elem_z;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        d1[k] <= DIFF_W'(ev[k]) - DIFF_W'(sv[k]);
        e1[k] <= el[k];
      end
    end
  end

  // Stage 2: cross-product terms and squares.
  logic signed [PROD_W-1:0] pa [3];
  logic signed [PROD_W-1:0] pb [3];
  logic        [SQ_W-1:0]   sq [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      pa[0] <= d1[1] * e1[2];
      pb[0] <= d1[2] * e1[1];
      pa[1] <= d1[2] * e1[0];
      pb[1] <= d1[0] * e1[2];
      pa[2] <= d1[0] * e1[1];
      pb[2] <= d1[1] * e1[0];
      for (int k = 0; k < 3; k++) begin
        sq[k] <= d1[k] * d1[k];
      end
    end
  end

  // Stage 3: cross product and squared distance.
  logic signed [CROSS_W-1:0] c3 [3];
  logic        [SUM_W-1:0]   s3;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        c3[k] <= CROSS_W'(pa[k]) - CROSS_W'(pb[k]);
      end
      s3 <= SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);
    end
  end

  // Stage 4: magnitudes, result signs and the coincident-point flag.
  logic [2:0][CROSS_W-1:0] absv;
  logic [2:0][MAG_W-1:0]   mag4;
  logic [SUM_W-1:0]        s4;
  flag_t                   flag4;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      absv[k] = c3[k][CROSS_W-1] ? CROSS_W'(-c3[k]) : CROSS_W'(c3[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        mag4[k]       <= absv[k][MAG_W-1:0];
        flag4.rneg[k] <= !c3[k][CROSS_W-1] && (c3[k] != '0);
      end
      flag4.coinc <= (s3 == '0);
      s4          <= s3;
    end
  end

  // Distance with guard bits.
  logic [ROOT_W-1:0] root;
  logic [SUM_W-1:0]  s_sq;

  bsk_sqrt u_sqrt (
    .clk     (clk),
    .en      (adv),
    .rad     (s4),
    .root    (root),
    .rad_out (s_sq)
  );

  // Denominator s * q from 32-bit limb products, then row and final sums.
  logic [NA*LIMB_W-1:0] a_pad;
  logic [NB*LIMB_W-1:0] b_pad;
  logic [2*LIMB_W-1:0]  pp [NA][NB];
  logic [MPROD_W-1:0]   row_next [NA];
  logic [MPROD_W-1:0]   row [NA];
  logic [MPROD_W-1:0]   den_next;
  logic [DEN_W-1:0]     den;

  assign a_pad = (NA*LIMB_W)'(s_sq);
  assign b_pad = (NB*LIMB_W)'(root);

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp[i][j] <= (2*LIMB_W)'(a_pad[i*LIMB_W +: LIMB_W]) *
                      (2*LIMB_W)'(b_pad[j*LIMB_W +: LIMB_W]);
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_next[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_next[i] = row_next[i] + (MPROD_W'(pp[i][j]) << (j*LIMB_W));
      end
    end
    den_next = '0;
    for (int i = 0; i < NA; i++) begin
      den_next = den_next + (row[i] << (i*LIMB_W));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      row <= row_next;
      den <= den_next[DEN_W-1:0];
    end
  end

  // Magnitudes and flags wait for the denominator and the quotients.
  logic [2:0][MAG_W-1:0] mag_dly  [MAG_LAT];
  flag_t                 flag_dly [FLAG_LAT];

  always_ff @(posedge clk) begin
    if (adv) begin
      mag_dly[0]  <= mag4;
      flag_dly[0] <= flag4;
      for (int i = 1; i < MAG_LAT; i++) begin
        mag_dly[i] <= mag_dly[i-1];
      end
      for (int i = 1; i < FLAG_LAT; i++) begin
        flag_dly[i] <= flag_dly[i-1];
      end
    end
  end

  // Quotients of the three components.
  logic [2:0][QUO_W:0] quo;
  logic [2:0]          big;

  bsk_div u_div (
    .clk (clk),
    .en  (adv),
    .den (den),
    .mag (mag_dly[MAG_LAT-1]),
    .quo (quo),
    .big (big)
  );

  // Output stage: sign, saturation and status.
  localparam logic [QUO_W:0] TOP = (QUO_W+1)'(1) << (COORD_WIDTH-1);

  flag_t                          flag_o;
  logic [2:0][COORD_WIDTH-1:0]    fld;
  logic [2:0]                     sat;
  logic [2:0][QUO_W:0]            negq;
  result_t                        result_next;

  assign flag_o = flag_dly[FLAG_LAT-1];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      negq[k] = (QUO_W+1)'(0) - quo[k];
      sat[k]  = 1'b0;
      if (flag_o.rneg[k]) begin
        if (big[k] || (quo[k] > TOP)) begin
          fld[k] = TOP[COORD_WIDTH-1:0];
          sat[k] = 1'b1;
        end else begin
          fld[k] = negq[k][COORD_WIDTH-1:0];
        end
      end else begin
        if (big[k] || (quo[k] > TOP - 1'b1)) begin
          fld[k] = TOP[COORD_WIDTH-1:0] - 1'b1;
          sat[k] = 1'b1;
        end else begin
          fld[k] = quo[k][COORD_WIDTH-1:0];
        end
      end
    end
    if (flag_o.coinc) begin
      result_next.field_x = '0;
      result_next.field_y = '0;
      result_next.field_z = '0;
      result_next.status  = STATUS_COINCIDENT;
    end else begin
      result_next.field_x = fld[0];
      result_next.field_y = fld[1];
      result_next.field_z = fld[2];
      result_next.status  = (sat != '0) ? STATUS_SAT : STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result <= result_next;
    end
  end

`ifndef SYNTHESIS
  // A coincident pair always reports a zero field.
  a_coinc_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status == STATUS_COINCIDENT) |->
      (result.field_x == '0) && (result.field_y == '0) && (result.field_z == '0))
    else $error("coincident result with nonzero field");

  // A saturated result has at least one component at a limit.
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status == STATUS_SAT) |->
      (result.field_x == TOP[COORD_WIDTH-1:0]) ||
      (result.field_x == TOP[COORD_WIDTH-1:0] - 1'b1) ||
      (result.field_y == TOP[COORD_WIDTH-1:0]) ||
      (result.field_y == TOP[COORD_WIDTH-1:0] - 1'b1) ||
      (result.field_z == TOP[COORD_WIDTH-1:0]) ||
      (result.field_z == TOP[COORD_WIDTH-1:0] - 1'b1))
    else $error("saturated status without a limit value");

  // No result is pending in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid right after reset");
`endif

endmodule

// ===== rtl/bsk_sqrt.sv =====
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Computes floor(sqrt(rad * 2^(2*SQRT_GUARD))) one root bit per stage and
// carries the radicand alongside so it leaves together with its root.
// ----------------------------------------------------------------------------
module bsk_sqrt import bsk_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [SUM_W-1:0]  rad,
  output logic [ROOT_W-1:0] root,
  output logic [SUM_W-1:0]  rad_out
);

  logic [ROOT_W:0]   rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic [SUM_W-1:0]  rad_q  [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam int BI = ROOT_W - 1 - k;
    logic [ROOT_W:0]   rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [SUM_W-1:0]  rad_in;
    logic [1:0]        pair;
    logic [ROOT_W+2:0] cand;
    logic [ROOT_W+2:0] trial;
    logic [ROOT_W+2:0] diff;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
    end

    // The guard bits below the radicand are zero pairs.
    if (BI >= SQRT_GUARD) begin : g_pair
      assign pair = rad_in[2*(BI-SQRT_GUARD)+1 -: 2];
    end else begin : g_zero
      assign pair = 2'b00;
    end

    assign cand  = {rem_in, pair};
    assign trial = {1'b0, root_in, 2'b01};
    assign diff  = cand - trial;

    // One restoring step: keep the trial bit when the remainder covers it.
    always_ff @(posedge clk) begin
      if (en) begin
        rad_q[k] <= rad_in;
        if (cand >= trial) begin
          rem_q[k]  <= diff[ROOT_W:0];
          root_q[k] <= {root_in[ROOT_W-2:0], 1'b1};
        end else begin
          rem_q[k]  <= cand[ROOT_W:0];
          root_q[k] <= {root_in[ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  assign root    = root_q[ROOT_W-1];
  assign rad_out = rad_q[ROOT_W-1];

endmodule

// ===== rtl/bsk_div.sv =====
// ----------------------------------------------------------------------------
// Pipelined three-lane divider
// Divides (mag << NUM_SHIFT) by a shared denominator, one quotient bit per
// stage, flags quotients too large for the result and rounds to nearest.
// ----------------------------------------------------------------------------
module bsk_div import bsk_pkg::*; (
  input  logic                  clk,
  input  logic                  en,
  input  logic [DEN_W-1:0]      den,
  input  logic [2:0][MAG_W-1:0] mag,
  output logic [2:0][QUO_W:0]   quo,
  output logic [2:0]            big
);

  logic [2:0][REM_W-1:0] rem_q  [QUO_W+1];
  logic [2:0][QUO_W-1:0] quo_q  [QUO_W+1];
  logic [2:0][QUO_W-1:0] nlow_q [QUO_W+1];
  logic [2:0]            big_q  [QUO_W+1];
  logic [DEN_W-1:0]      den_q  [QUO_W+1];

  // Entry stage: upper numerator bits form the first remainder.
  logic [2:0][NUM_W-1:0] nfull;
  logic [2:0][REM_W-1:0] rinit;
  logic [2:0]            over;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      nfull[c] = NUM_W'(mag[c]) << NUM_SHIFT;
      rinit[c] = REM_W'(nfull[c][NUM_W-1:QUO_W]);
      over[c]  = rinit[c] >= REM_W'(den);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_q[0] <= den;
      for (int c = 0; c < 3; c++) begin
        rem_q[0][c]  <= over[c] ? '0 : rinit[c];
        quo_q[0][c]  <= '0;
        nlow_q[0][c] <= nfull[c][QUO_W-1:0];
        big_q[0][c]  <= over[c];
      end
    end
  end

  // Restoring division steps, most significant quotient bit first.
  for (genvar k = 1; k <= QUO_W; k++) begin : g_step
    logic [2:0][REM_W-1:0] cand;
    logic [2:0]            ge;

    always_comb begin
      for (int c = 0; c < 3; c++) begin
        cand[c] = {rem_q[k-1][c][REM_W-2:0], nlow_q[k-1][c][QUO_W-k]};
        ge[c]   = cand[c] >= REM_W'(den_q[k-1]);
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_q[k] <= den_q[k-1];
        for (int c = 0; c < 3; c++) begin
          rem_q[k][c]  <= ge[c] ? cand[c] - REM_W'(den_q[k-1]) : cand[c];
          quo_q[k][c]  <= {quo_q[k-1][c][QUO_W-2:0], ge[c]};
          nlow_q[k][c] <= nlow_q[k-1][c];
          big_q[k][c]  <= big_q[k-1][c];
        end
      end
    end
  end

  // Round half away from zero on the magnitude.
  logic [2:0][REM_W-1:0] twice;
  logic [2:0]            rnd;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      twice[c] = {rem_q[QUO_W][c][REM_W-2:0], 1'b0};
      rnd[c]   = twice[c] >= REM_W'(den_q[QUO_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        quo[c] <= (QUO_W+1)'(quo_q[QUO_W][c]) + (QUO_W+1)'(rnd[c]);
        big[c] <= big_q[QUO_W][c];
      end
    end
  end

endmodule
